FILE: rtl/lws_pkg.sv
// ----------------------------------------------------------------------------
// lws_pkg
// Shared types, sizes and codes for the LIFO stack with remove-by-value.
// ----------------------------------------------------------------------------
package lws_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

   localparam func_type FN_PUSH   = 2'd0;
   localparam func_type FN_POP    = 2'd1;
   localparam func_type FN_REMOVE = 2'd2;
   localparam func_type FN_CLEAR  = 2'd3;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic                     start;
      func_type                 func;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                     idle;
      logic                     valid;
      status_type               status;
      logic signed [DATA_W-1:0] popped;
   } res_type;

endpackage

FILE: rtl/lws_ram.sv
// ----------------------------------------------------------------------------
// lws_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lws_engine.sv
// ----------------------------------------------------------------------------
// lws_engine
// Sequencer for push, pop, clear and remove. One comparator walks the slot
// RAM from the top down; a hit is closed by copying the entries above it
// down one place, one entry per cycle.
// ----------------------------------------------------------------------------
module lws_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  lws_pkg::cmd_type              cmd,
   input  logic                          out_free,
   output lws_pkg::res_type              res,
   output logic                          mem_we,
   output logic [lws_pkg::ADDR_W-1:0]    mem_waddr,
   output logic [lws_pkg::DATA_W-1:0]    mem_wdata,
   output logic [lws_pkg::ADDR_W-1:0]    mem_raddr,
   input  logic [lws_pkg::DATA_W-1:0]    mem_rdata
);
   import lws_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [DATA_W-1:0]        value_ff, value_in;
   status_type               status_ff, status_in;
   logic [DATA_W-1:0]        popped_ff, popped_in;
   logic                     hit;
   logic [CNT_W-1:0]         idx_ext;
   logic [ADDR_W-1:0]        top_addr;

   assign hit      = (mem_rdata == value_ff);
   assign idx_ext  = CNT_W'(idx_ff);
   assign top_addr = ADDR_W'(count_ff - CNT_W'(1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = mem_rdata;
      mem_raddr = idx_ff - ADDR_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               value_in  = cmd.value;
               status_in = ST_DONE;
               popped_in = '0;
               state_in  = S_DONE;
               unique case (cmd.func)
                  FN_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(count_ff);
                        mem_wdata = cmd.value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  FN_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_raddr = top_addr;
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = S_POP;
                     end
                  end
                  FN_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_raddr = top_addr;
                        idx_in    = top_addr;
                        state_in  = S_SCAN;
                     end
                  end
                  FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // rd data holds slot idx_ff; fetches slot below, or above on a hit
         S_SCAN: begin
            if (hit) begin
               if (idx_ext + CNT_W'(1) == count_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  mem_raddr = idx_ff + ADDR_W'(1);
                  state_in  = S_SHIFT;
               end
            end else if (idx_ff == '0) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_ff - ADDR_W'(1);
            end
         end
         // rd data holds slot idx_ff+1, written down into idx_ff
         S_SHIFT: begin
            mem_we = 1'b1;
            if (idx_ext + CNT_W'(2) == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in    = idx_ff + ADDR_W'(1);
               mem_raddr = idx_ff + ADDR_W'(2);
            end
         end
         S_POP: begin
            popped_in = mem_rdata;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign res.idle   = (state_ff == S_IDLE);
   assign res.valid  = (state_ff == S_DONE);
   assign res.status = status_ff;
   assign res.popped = popped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_we)
      else $error("slot write during scan");

   a_shift_ports_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (mem_raddr != mem_waddr))
      else $error("shift reads the slot it writes");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (idx_ext + CNT_W'(2) <= count_ff))
      else $error("shift past top of stack");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |=> (state_ff == S_DONE && status_ff == ST_DONE))
      else $error("pop did not finish cleanly");

endmodule

FILE: rtl/lifo_stack_with_remove.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_remove
// Bounded LIFO of signed 32-bit values with push, pop, clear and
// remove-first-match-from-top.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   req     | req_valid/ready, func, value   | in
//   rsp     | rsp_valid/ready, status, popped| out
//
// Pop and remove on an empty stack finish without reading the RAM. Remove
// scans from the top for the first match and then closes the gap; the
// single RAM read port feeds one compare or one copy per cycle.
// Reset empties the stack; slot contents are left as they are.
// A finished transaction sits in the output register while the next request
// is taken; the sequencer waits in its finish state if it is full and unread.
// ----------------------------------------------------------------------------
module lifo_stack_with_remove (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lws_pkg::func_type             req_func,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lws_pkg::status_type           rsp_status,
   output logic signed [31:0]            rsp_popped
);
   import lws_pkg::*;

   cmd_type            cmd;
   res_type            res;
   logic               out_free;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [DATA_W-1:0]  mem_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [DATA_W-1:0]  rsp_popped_ff;
   logic               load;

   assign req_ready = res.idle;
   assign cmd.start = req_valid & res.idle;
   assign cmd.func  = req_func;
   assign cmd.value = req_value;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign load         = res.valid && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   lws_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .out_free  (out_free),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   lws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_status_ff <= res.status;
         rsp_popped_ff <= res.popped;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_popped = rsp_popped_ff;

endmodule
